/* rtl/fpa_pkg.sv */
// Shared types and constants for the fixed-point ALU.
package fpa_pkg;

    localparam int W = 32;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MIN = 4'd4,
        OP_MAX = 4'd5,
        OP_INC = 4'd6,
        OP_I2F = 4'd7,
        OP_F2I = 4'd8
    } t_op;

    // Data that rides alongside the divider chain.
    typedef struct packed {
        logic [3:0]          op;
        logic [W-1:0]        simple;
        logic                s_ovf;
        logic                gt;
        logic                lt;
        logic                eq;
        logic signed [2*W-1:0] prod;
        logic                neg;
        logic                dz;
    } t_side;

endpackage

/* rtl/fpa_front.sv */
// Input stage: decode, simple ops, product, divider operand setup.
module fpa_front #(
    parameter int FRAC_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  logic [3:0]                  i_op,
    input  logic signed [31:0]          i_a_raw,
    input  logic signed [31:0]          i_b_raw,
    output logic                        o_valid,
    output logic [31:0]                 o_rem,
    output logic [31:0]                 o_dv,
    output logic [32+FRAC_W-1:0]        o_dend,
    output logic [32+FRAC_W-1:0]        o_q,
    output fpa_pkg::t_side              o_side
);
    import fpa_pkg::*;

    localparam int N = W + FRAC_W;

    logic signed [W:0]   sum;
    logic signed [N-1:0] ext;
    logic [W-1:0]        mag_a, mag_b;
    t_side               n_side;
    logic                r_valid;
    t_side               r_side;
    logic [W-1:0]        r_dv;
    logic [N-1:0]        r_dend;

    always_comb begin
        mag_a = i_a_raw[W-1] ? (W)'(-i_a_raw) : i_a_raw;
        mag_b = i_b_raw[W-1] ? (W)'(-i_b_raw) : i_b_raw;
        ext   = (N)'(i_a_raw) <<< FRAC_W;
        sum   = '0;
        n_side        = '0;
        n_side.op     = i_op;
        n_side.gt     = i_a_raw > i_b_raw;
        n_side.lt     = i_a_raw < i_b_raw;
        n_side.eq     = i_a_raw == i_b_raw;
        n_side.prod   = (2*W)'(i_a_raw) * (2*W)'(i_b_raw);
        n_side.neg    = i_a_raw[W-1] ^ i_b_raw[W-1];
        n_side.dz     = i_b_raw == '0;
        case (t_op'(i_op))
            OP_ADD: begin
                sum = (W+1)'(i_a_raw) + (W+1)'(i_b_raw);
                n_side.simple = sum[W-1:0];
                n_side.s_ovf  = sum[W] != sum[W-1];
            end
            OP_SUB: begin
                sum = (W+1)'(i_a_raw) - (W+1)'(i_b_raw);
                n_side.simple = sum[W-1:0];
                n_side.s_ovf  = sum[W] != sum[W-1];
            end
            OP_INC: begin
                sum = (W+1)'(i_a_raw) + (W+1)'(1);
                n_side.simple = sum[W-1:0];
                n_side.s_ovf  = sum[W] != sum[W-1];
            end
            OP_MIN: n_side.simple = (i_a_raw <= i_b_raw) ? i_a_raw : i_b_raw;
            OP_MAX: n_side.simple = (i_a_raw >= i_b_raw) ? i_a_raw : i_b_raw;
            OP_I2F: begin
                n_side.simple = ext[W-1:0];
                n_side.s_ovf  = ext[N-1:W-1] != {(FRAC_W+1){ext[W-1]}};
            end
            OP_F2I: n_side.simple = W'(i_a_raw >>> FRAC_W);
            default: n_side.simple = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side <= n_side;
            r_dv   <= mag_b;
            r_dend <= {mag_a, {FRAC_W{1'b0}}};
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_dv    = r_dv;
    assign o_dend  = r_dend;
    assign o_rem   = '0;
    assign o_q     = '0;
endmodule

/* rtl/fpa_div_stage.sv */
// One restoring-division step: one quotient bit per stage.
module fpa_div_stage #(
    parameter int N = 40
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  logic [31:0]    i_rem,
    input  logic [31:0]    i_dv,
    input  logic [N-1:0]   i_dend,
    input  logic [N-1:0]   i_q,
    input  fpa_pkg::t_side i_side,
    output logic           o_valid,
    output logic [31:0]    o_rem,
    output logic [31:0]    o_dv,
    output logic [N-1:0]   o_dend,
    output logic [N-1:0]   o_q,
    output fpa_pkg::t_side o_side
);
    import fpa_pkg::*;

    logic [W:0] trial, diff;
    logic       ge;

    always_comb begin
        trial = {i_rem, i_dend[N-1]};
        diff  = trial - {1'b0, i_dv};
        ge    = trial >= {1'b0, i_dv};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_rem  <= ge ? diff[W-1:0] : trial[W-1:0];
            o_dv   <= i_dv;
            o_dend <= {i_dend[N-2:0], 1'b0};
            o_q    <= {i_q[N-2:0], ge};
            o_side <= i_side;
        end
    end
endmodule

/* rtl/fpa_back.sv */
// Output stage: quotient sign fix, product scaling, result select.
module fpa_back #(
    parameter int FRAC_W = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  logic [32+FRAC_W-1:0]    i_q,
    input  fpa_pkg::t_side          i_side,
    output logic                    o_valid,
    output logic signed [31:0]      o_result_raw,
    output logic                    o_a_greater,
    output logic                    o_a_less,
    output logic                    o_a_equal,
    output logic                    o_overflow,
    output logic                    o_div_zero
);
    import fpa_pkg::*;

    localparam int N = W + FRAC_W;

    logic signed [2*W-1:0] pbias, pq;
    logic [N:0]            sq;
    logic [W-1:0]          n_res;
    logic                  n_ovf, n_dz;

    always_comb begin
        // truncate toward zero: bias negatives before the shift
        pbias = i_side.prod + (i_side.prod[2*W-1] ? (2*W)'((64'd1 << FRAC_W) - 64'd1)
                                                   : (2*W)'(0));
        pq    = pbias >>> FRAC_W;
        sq    = i_side.neg ? (N+1)'(-{1'b0, i_q}) : {1'b0, i_q};
        n_res = i_side.simple;
        n_ovf = i_side.s_ovf;
        n_dz  = 1'b0;
        case (t_op'(i_side.op))
            OP_MUL: begin
                n_res = pq[W-1:0];
                n_ovf = pq[2*W-1:W-1] != {(W+1){pq[W-1]}};
            end
            OP_DIV: begin
                if (i_side.dz) begin
                    n_res = '0;
                    n_ovf = 1'b0;
                    n_dz  = 1'b1;
                end else begin
                    n_res = sq[W-1:0];
                    n_ovf = sq[N:W-1] != {(FRAC_W+2){sq[W-1]}};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_result_raw <= n_res;
            o_a_greater  <= i_side.gt;
            o_a_less     <= i_side.lt;
            o_a_equal    <= i_side.eq;
            o_overflow   <= n_ovf;
            o_div_zero   <= n_dz;
        end
    end
endmodule

/* rtl/fixed_point_alu_q24_8.sv */
// Top level of the pipelined signed fixed-point ALU.
// Signed Q(32-FRAC_W).FRAC_W ALU: add, sub, mul, div, min, max, increment and
// int/fixed conversions with compare, overflow and divide-by-zero flags. It accepts
// one request per cycle while o_stall is low; each request passes through one input
// stage, a radix-2 divider that resolves one of its 32+FRAC_W quotient bits per
// stage, and one output stage.
// All stages advance together; the pipeline holds while the result waits on i_stall.
module fixed_point_alu_q24_8 #(
    parameter int FRAC_W = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_op,
    input  logic signed [31:0] i_a_raw,
    input  logic signed [31:0] i_b_raw,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_raw,
    output logic               o_a_greater,
    output logic               o_a_less,
    output logic               o_a_equal,
    output logic               o_overflow,
    output logic               o_div_zero
);
    import fpa_pkg::*;

    localparam int N = W + FRAC_W;

    logic         adv;
    logic         s_valid [N+1];
    logic [W-1:0] s_rem   [N+1];
    logic [W-1:0] s_dv    [N+1];
    logic [N-1:0] s_dend  [N+1];
    logic [N-1:0] s_q     [N+1];
    t_side        s_side  [N+1];

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    fpa_front #(.FRAC_W(FRAC_W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv), .i_valid(i_valid),
        .i_op(i_op), .i_a_raw(i_a_raw), .i_b_raw(i_b_raw),
        .o_valid(s_valid[0]), .o_rem(s_rem[0]), .o_dv(s_dv[0]),
        .o_dend(s_dend[0]), .o_q(s_q[0]), .o_side(s_side[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_div
        fpa_div_stage #(.N(N)) u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
            .i_valid(s_valid[g]), .i_rem(s_rem[g]), .i_dv(s_dv[g]),
            .i_dend(s_dend[g]), .i_q(s_q[g]), .i_side(s_side[g]),
            .o_valid(s_valid[g+1]), .o_rem(s_rem[g+1]), .o_dv(s_dv[g+1]),
            .o_dend(s_dend[g+1]), .o_q(s_q[g+1]), .o_side(s_side[g+1])
        );
    end

    fpa_back #(.FRAC_W(FRAC_W)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
        .i_valid(s_valid[N]), .i_q(s_q[N]), .i_side(s_side[N]),
        .o_valid(o_valid), .o_result_raw(o_result_raw),
        .o_a_greater(o_a_greater), .o_a_less(o_a_less), .o_a_equal(o_a_equal),
        .o_overflow(o_overflow), .o_div_zero(o_div_zero)
    );

    // remainder, divisor and dividend leave the last stage unused
    logic unused_tail;
    assign unused_tail = ^{s_rem[N], s_dv[N], s_dend[N]};
endmodule
